/* sv/lfu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants of the LFU cache table
// Holds the operation codes, the configuration register map and the
// structs that carry lookup and victim results between the modules.
// ----------------------------------------------------------------------------
package lfu_pkg;

  // Widest slot index over the supported table sizes (up to 64 records).
  localparam int LFU_IDX_MAX_W = 6;

  // Configuration register map.
  localparam int PADDR_WIDTH = 3;
  localparam int PDATA_WIDTH = 32;
  localparam int CFG_WIDTH   = 5;
  localparam logic [CFG_WIDTH-1:0] CAP_RESET = 5'd16;
  localparam logic REG_ACTIVE_ENTRIES = 1'b0;

  // Request operation codes.
  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_SET = 1'b1
  } lfu_func_t;

  // Result of the parallel key compare and free slot search.
  typedef struct packed {
    logic                     hit;
    logic [LFU_IDX_MAX_W-1:0] hit_idx;
    logic                     free_found;
    logic [LFU_IDX_MAX_W-1:0] free_idx;
  } lfu_match_t;

  // Result of the replacement victim search.
  typedef struct packed {
    logic                     found;
    logic [LFU_IDX_MAX_W-1:0] idx;
  } lfu_victim_t;

endpackage

/* sv/lfu_match.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_match: parallel key lookup
// Compares the request key against every valid slot and finds the
// lowest-numbered free slot, both in one pass.
// ----------------------------------------------------------------------------
module lfu_match import lfu_pkg::*; #(
  parameter int ENTRIES   = 16,
  parameter int KEY_WIDTH = 8
) (
  input  logic                 slot_valid [ENTRIES],
  input  logic [KEY_WIDTH-1:0] slot_key   [ENTRIES],
  input  logic [KEY_WIDTH-1:0] key,
  output lfu_match_t           match
);

  // Walk from the top slot down so that the lowest index wins.
  always_comb begin
    match = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (slot_valid[i] && (slot_key[i] == key)) begin
        match.hit     = 1'b1;
        match.hit_idx = LFU_IDX_MAX_W'(i);
      end
      if (!slot_valid[i]) begin
        match.free_found = 1'b1;
        match.free_idx   = LFU_IDX_MAX_W'(i);
      end
    end
  end

endmodule

/* sv/lfu_victim.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_victim: replacement victim search
// A compare tree over all slots picks the valid record with the lowest
// use count, and among equal counts the oldest (highest recency rank).
// ----------------------------------------------------------------------------
module lfu_victim import lfu_pkg::*; #(
  parameter int ENTRIES     = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   slot_valid [ENTRIES],
  input  logic [COUNT_WIDTH-1:0] use_count  [ENTRIES],
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rank [ENTRIES],
  output lfu_victim_t            victim
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LEAVES = 1 << IDX_W;
  localparam int NODES  = 2 * LEAVES;

  logic                     nd_valid [NODES];
  logic [COUNT_WIDTH-1:0]   nd_cnt   [NODES];
  logic [IDX_W-1:0]         nd_rank  [NODES];
  logic [LFU_IDX_MAX_W-1:0] nd_idx   [NODES];
  logic                     take_b;

  // Leaves at LEAVES..NODES-1, node n combines children 2n and 2n+1.
  always_comb begin
    take_b = 1'b0;
    for (int n = 0; n < NODES; n++) begin
      nd_valid[n] = 1'b0;
      nd_cnt[n]   = '0;
      nd_rank[n]  = '0;
      nd_idx[n]   = '0;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      nd_valid[LEAVES + i] = slot_valid[i];
      nd_cnt[LEAVES + i]   = use_count[i];
      nd_rank[LEAVES + i]  = rank[i];
      nd_idx[LEAVES + i]   = LFU_IDX_MAX_W'(i);
    end
    for (int n = LEAVES - 1; n >= 1; n--) begin
      take_b = nd_valid[2*n+1] &&
               (!nd_valid[2*n] ||
                (nd_cnt[2*n+1] < nd_cnt[2*n]) ||
                ((nd_cnt[2*n+1] == nd_cnt[2*n]) && (nd_rank[2*n+1] > nd_rank[2*n])));
      if (take_b) begin
        nd_valid[n] = nd_valid[2*n+1];
        nd_cnt[n]   = nd_cnt[2*n+1];
        nd_rank[n]  = nd_rank[2*n+1];
        nd_idx[n]   = nd_idx[2*n+1];
      end else begin
        nd_valid[n] = nd_valid[2*n];
        nd_cnt[n]   = nd_cnt[2*n];
        nd_rank[n]  = nd_rank[2*n];
        nd_idx[n]   = nd_idx[2*n];
      end
    end
  end

  assign victim.found = nd_valid[1];
  assign victim.idx   = nd_idx[1];

endmodule

/* sv/lfu_cache_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_table: key-value table with LFU replacement and LRU tie break
// Each request is a get or a set of one key. Hits bump a saturating use
// count and make the record most recent; a set miss fills a free slot or
// evicts the least used, oldest record and reports its key.
//
//   Channel  Direction  Handshake                          Moves
//   in_      input      in_valid / in_ready                func, key, value
//   out_     output     out_valid / out_ready              hit, read_value,
//                                                          evicted, evicted_key
//   cfg      input      psel / penable / pwrite / pready   active_entries
//
// A request is registered on acceptance, then looked up and applied when the
// result register can take it; its result is registered at the same edge
// that updates the table. One request per cycle is sustained while the result
// channel does not stall. The lookup, victim compare tree and recency update
// are combinational between the input register and the result register.
// A stalled result holds the pipeline; the input register refills as soon
// as the result register is taken. Reset (rst_n, synchronous) empties the
// table and sets active_entries to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lfu_cache_table import lfu_pkg::*; #(
  parameter int ENTRIES     = 16,
  parameter int KEY_WIDTH   = 8,
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic [KEY_WIDTH-1:0]          in_key,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic signed [VALUE_WIDTH-1:0] out_read_value,
  output logic                          out_evicted,
  output logic [KEY_WIDTH-1:0]          out_evicted_key,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_WIDTH-1:0]        paddr,
  input  logic [PDATA_WIDTH-1:0]        pwdata,
  output logic [PDATA_WIDTH-1:0]        prdata,
  output logic                          pready
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W = $clog2(ENTRIES + 1);
  localparam int CAP_W  = (FILL_W > CFG_WIDTH) ? FILL_W : CFG_WIDTH;

  // Configuration register
  logic [CFG_WIDTH-1:0] active_entries_r;

  // Table state
  logic                   slot_valid_r [ENTRIES];
  logic [KEY_WIDTH-1:0]   slot_key_r   [ENTRIES];
  logic [VALUE_WIDTH-1:0] slot_value_r [ENTRIES];
  logic [COUNT_WIDTH-1:0] use_count_r  [ENTRIES];
  logic [IDX_W-1:0]       rank_r       [ENTRIES];
  logic [IDX_W-1:0]       rank_nxt     [ENTRIES];
  logic [FILL_W-1:0]      filled_r;

  // Input register
  logic                   s1_valid_r;
  lfu_func_t              s1_func_r;
  logic [KEY_WIDTH-1:0]   s1_key_r;
  logic [VALUE_WIDTH-1:0] s1_value_r;

  // Result register
  logic                   out_valid_r;
  logic                   out_hit_r;
  logic [VALUE_WIDTH-1:0] out_read_value_r;
  logic                   out_evicted_r;
  logic [KEY_WIDTH-1:0]   out_evicted_key_r;

  lfu_match_t  match;
  lfu_victim_t victim;

  logic             adv;
  logic             proc;
  logic [CAP_W-1:0] cap_raw;
  logic [CAP_W-1:0] cap;
  logic             full;
  logic             do_hit;
  logic             do_evict;
  logic             do_fill;
  logic             upd;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] vict_idx;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] tgt;
  logic [IDX_W-1:0] tgt_rank;
  logic [COUNT_WIDTH-1:0] count_nxt;

  // Handshakes
  assign adv      = !out_valid_r || out_ready;
  assign proc     = s1_valid_r && adv;
  assign in_ready = !s1_valid_r || adv;

  // Configuration port: always ready, one register at index zero.
  assign pready = 1'b1;

  always_comb begin
    if (paddr[2] == REG_ACTIVE_ENTRIES) begin
      prdata = PDATA_WIDTH'(active_entries_r);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_entries_r <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_ENTRIES)) begin
      active_entries_r <= pwdata[CFG_WIDTH-1:0];
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func_r  <= lfu_func_t'(in_func);
      s1_key_r   <= in_key;
      s1_value_r <= in_value;
    end
  end

  // Lookup and victim search
  lfu_match #(
    .ENTRIES   (ENTRIES),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_match (
    .slot_valid (slot_valid_r),
    .slot_key   (slot_key_r),
    .key        (s1_key_r),
    .match      (match)
  );

  lfu_victim #(
    .ENTRIES     (ENTRIES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_victim (
    .slot_valid (slot_valid_r),
    .use_count  (use_count_r),
    .rank       (rank_r),
    .victim     (victim)
  );

  // Effective capacity: zero acts as one, anything above the table size is clamped.
  assign cap_raw = CAP_W'(active_entries_r);

  always_comb begin
    if (cap_raw == '0) begin
      cap = CAP_W'(1);
    end else if (cap_raw > CAP_W'(ENTRIES)) begin
      cap = CAP_W'(ENTRIES);
    end else begin
      cap = cap_raw;
    end
  end

  assign full = (CAP_W'(filled_r) >= cap);

  // Decide what the request does to the table.
  assign hit_idx  = match.hit_idx[IDX_W-1:0];
  assign vict_idx = victim.idx[IDX_W-1:0];
  assign free_idx = match.free_idx[IDX_W-1:0];

  assign do_hit   = match.hit;
  assign do_evict = !match.hit && (s1_func_r == FUNC_SET) && full && victim.found;
  assign do_fill  = !match.hit && (s1_func_r == FUNC_SET) && !full && match.free_found;
  assign upd      = proc && (do_hit || do_evict || do_fill);

  always_comb begin
    if (do_hit) begin
      tgt = hit_idx;
    end else if (do_evict) begin
      tgt = vict_idx;
    end else begin
      tgt = free_idx;
    end
  end

  assign tgt_rank = rank_r[tgt];

  // Hits bump the count up to saturation; new records start at one.
  always_comb begin
    if (do_hit) begin
      count_nxt = (use_count_r[tgt] == '1) ? use_count_r[tgt] :
                  use_count_r[tgt] + COUNT_WIDTH'(1);
    end else begin
      count_nxt = COUNT_WIDTH'(1);
    end
  end

  // Recency: the target becomes rank zero; valid records more recent than
  // it age by one. A fresh fill ages every valid record.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (IDX_W'(i) == tgt) begin
        rank_nxt[i] = '0;
      end else if (slot_valid_r[i] && (do_fill || (rank_r[i] < tgt_rank))) begin
        rank_nxt[i] = rank_r[i] + IDX_W'(1);
      end else begin
        rank_nxt[i] = rank_r[i];
      end
    end
  end

  // Table update: valid bits and fill count are control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid_r[i] <= 1'b0;
      end
    end else if (upd && do_fill) begin
      filled_r          <= filled_r + FILL_W'(1);
      slot_valid_r[tgt] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      use_count_r[tgt] <= count_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
      if (!do_hit) begin
        slot_key_r[tgt] <= s1_key_r;
      end
      if (s1_func_r == FUNC_SET) begin
        slot_value_r[tgt] <= s1_value_r;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_hit_r         <= do_hit;
      out_read_value_r  <= (do_hit && (s1_func_r == FUNC_GET)) ? slot_value_r[hit_idx] : '0;
      out_evicted_r     <= do_evict;
      out_evicted_key_r <= do_evict ? slot_key_r[vict_idx] : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_read_value_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

endmodule

/* sv/lfu_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_chk: port-level checks for the LFU cache table
// Watches the result channel for consistency of the reported fields and
// for correct behavior around reset and stalls.
// ----------------------------------------------------------------------------
module lfu_chk #(
  parameter int KEY_WIDTH   = 8,
  parameter int VALUE_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_hit,
  input logic signed [VALUE_WIDTH-1:0] out_read_value,
  input logic                          out_evicted,
  input logic [KEY_WIDTH-1:0]          out_evicted_key
);

  // A result is never shown in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // An eviction only happens on a miss.
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted))
    else $error("eviction reported on a hit");

  // No eviction means the reported key is zero.
  a_evict_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted |-> out_evicted_key == '0)
    else $error("evicted key nonzero without eviction");

  // A miss never returns data.
  a_miss_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_read_value == '0)
    else $error("read data nonzero on a miss");

endmodule

bind lfu_cache_table lfu_chk #(
  .KEY_WIDTH   (KEY_WIDTH),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_lfu_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_hit         (out_hit),
  .out_read_value  (out_read_value),
  .out_evicted     (out_evicted),
  .out_evicted_key (out_evicted_key)
);
